### rtl/three_way_quicksort_assert.svh
// ----------------------------------------------------------------------------
// three_way_quicksort assertion macros
// concurrent checks sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef THREE_WAY_QUICKSORT_ASSERT_SVH
`define THREE_WAY_QUICKSORT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define TWQS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TWQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/twqs_pkg.sv
// ----------------------------------------------------------------------------
// twqs_pkg
// shared types, constants and datapath command codes of the quicksort block
// ----------------------------------------------------------------------------
package twqs_pkg;

  localparam int ELEM_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int LFSR_W           = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     final_element;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflow;
  } out_item_t;

  // one datapath command per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_POP,
    OP_RANGE,
    OP_PIV_MUL,
    OP_PIV_RD,
    OP_PIV_SET,
    OP_SCAN_RD,
    OP_LESS_WR,
    OP_LESS_FIN,
    OP_GT_RD,
    OP_GT_WR1,
    OP_GT_WR2,
    OP_EQ_INC,
    OP_PUSH_LO,
    OP_PUSH_HI,
    OP_EMIT_RD,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    logic sp_zero;
    logic range_ok;
    logic scan_more;
    logic less;
    logic greater;
    logic emit_last;
  } dp_status_t;

endpackage

### rtl/three_way_quicksort.sv
// ----------------------------------------------------------------------------
// three_way_quicksort
// loads a set of signed elements, sorts it with three-way partition quicksort
// on an explicit range stack, then streams the set out in ascending order
// ----------------------------------------------------------------------------
//
//   channel  ports                      transfer when
//   -------  -------------------------  -----------------------------------
//   input    start, busy, in_data       start high and busy low
//   result   out_valid, out_data        out_valid high (one cycle each)
//
// a load is taken in the cycle it is offered and loads can come back to back
// the final element raises busy through init, the sort, the emission and the clear
// partition steps compare an element, swap a less or greater one, one ram write port
// each popped range is checked; a partitioned one gets a pivot, a scan and the pushes
// emission streams the results on consecutive cycles that cannot be held off
// rst_n is synchronous and active low; the stores need no clearing pass
//
module three_way_quicksort
  import twqs_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  // command and status between sequencer and datapath
  dp_op_t     op;
  dp_status_t status;

  // sequencer: load, pop range, pick pivot, scan, push subranges, emit
  twqs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .final_element (in_data.final_element),
    .status        (status),
    .op            (op),
    .busy          (busy)
  );

  // datapath: element store, range stack, pointers, lfsr, result port
  twqs_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### rtl/twqs_ram.sv
// ----------------------------------------------------------------------------
// twqs_ram
// generic ram, one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module twqs_ram
  import twqs_pkg::*;
#(
  parameter int WIDTH = ELEM_W,
  parameter int DEPTH = MAX_ELEMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_r <= mem_r[raddr_a];
    end
    if (re_b) begin
      rd_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

### rtl/twqs_ctrl.sv
// ----------------------------------------------------------------------------
// twqs_ctrl
// sequencer for load, partition loop, range stack and emission
// ----------------------------------------------------------------------------
module twqs_ctrl
  import twqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       final_element,
  input  dp_status_t status,
  output dp_op_t     op,
  output logic       busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_RANGE,
    S_CHECK,
    S_PIV_RD,
    S_PIV_SET,
    S_SCAN,
    S_CMP,
    S_LESS_FIN,
    S_GT_WR1,
    S_GT_WR2,
    S_PUSH_HI,
    S_EMIT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op = OP_LOAD;
          if (final_element) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        op        = OP_INIT;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (status.sp_zero) begin
          state_nxt = S_EMIT;
        end else begin
          op        = OP_POP;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        op        = OP_RANGE;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (status.range_ok) begin
          op        = OP_PIV_MUL;
          state_nxt = S_PIV_RD;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_PIV_RD: begin
        op        = OP_PIV_RD;
        state_nxt = S_PIV_SET;
      end
      S_PIV_SET: begin
        op        = OP_PIV_SET;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_more) begin
          op        = OP_SCAN_RD;
          state_nxt = S_CMP;
        end else begin
          op        = OP_PUSH_LO;
          state_nxt = S_PUSH_HI;
        end
      end
      S_CMP: begin
        if (status.less) begin
          op        = OP_LESS_WR;
          state_nxt = S_LESS_FIN;
        end else if (status.greater) begin
          op        = OP_GT_RD;
          state_nxt = S_GT_WR1;
        end else begin
          op        = OP_EQ_INC;
          state_nxt = S_SCAN;
        end
      end
      S_LESS_FIN: begin
        op        = OP_LESS_FIN;
        state_nxt = S_SCAN;
      end
      S_GT_WR1: begin
        op        = OP_GT_WR1;
        state_nxt = S_GT_WR2;
      end
      S_GT_WR2: begin
        op        = OP_GT_WR2;
        state_nxt = S_SCAN;
      end
      S_PUSH_HI: begin
        op        = OP_PUSH_HI;
        state_nxt = S_POP;
      end
      S_EMIT: begin
        op = OP_EMIT_RD;
        if (status.emit_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        op        = OP_CLEAR;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

### rtl/twqs_dpath.sv
// ----------------------------------------------------------------------------
// twqs_dpath
// element store, range stack, partition pointers, pivot lfsr and result port
// ----------------------------------------------------------------------------
module twqs_dpath
  import twqs_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_op_t     op,
  input  in_item_t   in_data,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int STK_W  = 2 * IDX_W;
  localparam int SPAN_W = IDX_W + 1;
  localparam int PROD_W = IDX_W + SPAN_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  sp_r, sp_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  lt_r, lt_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  gt_r, gt_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [ELEM_W-1:0] pivot_r, pivot_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              emit_pend_r, emit_pend_nxt;
  logic              last_r, last_nxt;

  logic              e_we, e_re_a, e_re_b;
  logic [IDX_W-1:0]  e_waddr, e_raddr_a, e_raddr_b;
  logic [ELEM_W-1:0] e_wdata, e_rdata_a, e_rdata_b;
  logic              s_we, s_re;
  logic [IDX_W-1:0]  s_waddr, s_raddr;
  logic [STK_W-1:0]  s_wdata, s_rdata;

  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] piv_off;
  logic [IDX_W-1:0]  piv_addr;
  logic [CNT_W-1:0]  lo_ext, hi_ext, sp_m1, gt_m1;
  logic              stk_room;

  assign lo_ext   = CNT_W'(lo_r);
  assign hi_ext   = CNT_W'(hi_r);
  assign sp_m1    = sp_r - ONE;
  assign gt_m1    = gt_r - ONE;
  assign stk_room = (sp_r < MAX_CNT);
  assign span     = SPAN_W'(hi_r) - SPAN_W'(lo_r) + SPAN_W'(1);
  // scaled lfsr sample, always below the span
  assign piv_off  = prod_r[PROD_W-1:IDX_W];
  assign piv_addr = lo_r + piv_off[IDX_W-1:0];

  assign status.sp_zero   = (sp_r == '0);
  assign status.range_ok  = (lo_r < hi_r);
  assign status.scan_more = (i_r < gt_r);
  assign status.less      = ($signed(e_rdata_a) < $signed(pivot_r));
  assign status.greater   = ($signed(pivot_r) < $signed(e_rdata_a));
  assign status.emit_last = (k_r == count_r - ONE);

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    sp_nxt        = sp_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    lt_nxt        = lt_r;
    i_nxt         = i_r;
    gt_nxt        = gt_r;
    k_nxt         = k_r;
    pivot_nxt     = pivot_r;
    lfsr_nxt      = lfsr_r;
    prod_nxt      = prod_r;
    emit_pend_nxt = 1'b0;
    last_nxt      = last_r;

    e_we      = 1'b0;
    e_waddr   = i_r[IDX_W-1:0];
    e_wdata   = e_rdata_a;
    e_re_a    = 1'b0;
    e_raddr_a = i_r[IDX_W-1:0];
    e_re_b    = 1'b0;
    e_raddr_b = lt_r[IDX_W-1:0];
    s_we      = 1'b0;
    s_waddr   = sp_r[IDX_W-1:0];
    s_wdata   = {lo_r, hi_r};
    s_re      = 1'b0;
    s_raddr   = sp_m1[IDX_W-1:0];

    unique case (op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        if (count_r < MAX_CNT) begin
          e_we      = 1'b1;
          e_waddr   = count_r[IDX_W-1:0];
          e_wdata   = in_data.element;
          count_nxt = count_r + ONE;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      OP_INIT: begin
        k_nxt  = '0;
        sp_nxt = '0;
        if (count_r > ONE) begin
          s_we    = 1'b1;
          s_waddr = '0;
          s_wdata = {IDX_W'(0), IDX_W'(count_r - ONE)};
          sp_nxt  = ONE;
        end
      end
      OP_POP: begin
        s_re   = 1'b1;
        sp_nxt = sp_m1;
      end
      OP_RANGE: begin
        lo_nxt = s_rdata[STK_W-1:IDX_W];
        hi_nxt = s_rdata[IDX_W-1:0];
      end
      OP_PIV_MUL: begin
        prod_nxt = PROD_W'(lfsr_r[IDX_W-1:0]) * PROD_W'(span);
      end
      OP_PIV_RD: begin
        e_re_a    = 1'b1;
        e_raddr_a = piv_addr;
      end
      OP_PIV_SET: begin
        pivot_nxt = e_rdata_a;
        lfsr_nxt  = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);
        lt_nxt    = lo_ext;
        i_nxt     = lo_ext;
        gt_nxt    = hi_ext + ONE;
      end
      OP_SCAN_RD: begin
        e_re_a    = 1'b1;
        e_raddr_a = i_r[IDX_W-1:0];
        e_re_b    = 1'b1;
        e_raddr_b = lt_r[IDX_W-1:0];
      end
      OP_LESS_WR: begin
        e_we    = 1'b1;
        e_waddr = lt_r[IDX_W-1:0];
        e_wdata = e_rdata_a;
      end
      OP_LESS_FIN: begin
        e_we    = 1'b1;
        e_waddr = i_r[IDX_W-1:0];
        e_wdata = e_rdata_b;
        lt_nxt  = lt_r + ONE;
        i_nxt   = i_r + ONE;
      end
      OP_GT_RD: begin
        e_re_b    = 1'b1;
        e_raddr_b = gt_m1[IDX_W-1:0];
        gt_nxt    = gt_m1;
      end
      OP_GT_WR1: begin
        e_we    = 1'b1;
        e_waddr = i_r[IDX_W-1:0];
        e_wdata = e_rdata_b;
      end
      OP_GT_WR2: begin
        e_we    = 1'b1;
        e_waddr = gt_r[IDX_W-1:0];
        e_wdata = e_rdata_a;
      end
      OP_EQ_INC: begin
        i_nxt = i_r + ONE;
      end
      OP_PUSH_LO: begin
        if (lt_r > lo_ext && stk_room) begin
          s_we    = 1'b1;
          s_wdata = {lo_r, IDX_W'(lt_r - ONE)};
          sp_nxt  = sp_r + ONE;
        end
      end
      OP_PUSH_HI: begin
        if (gt_r < hi_ext && stk_room) begin
          s_we    = 1'b1;
          s_wdata = {gt_r[IDX_W-1:0], hi_r};
          sp_nxt  = sp_r + ONE;
        end
      end
      OP_EMIT_RD: begin
        e_re_a        = 1'b1;
        e_raddr_a     = k_r[IDX_W-1:0];
        k_nxt         = k_r + ONE;
        emit_pend_nxt = 1'b1;
        last_nxt      = status.emit_last;
      end
      OP_CLEAR: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        sp_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sp_r        <= '0;
      lfsr_r      <= LFSR_SEED;
      emit_pend_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sp_r        <= sp_nxt;
      lfsr_r      <= lfsr_nxt;
      emit_pend_r <= emit_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    lt_r    <= lt_nxt;
    i_r     <= i_nxt;
    gt_r    <= gt_nxt;
    k_r     <= k_nxt;
    pivot_r <= pivot_nxt;
    prod_r  <= prod_nxt;
    last_r  <= last_nxt;
  end

  twqs_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_elem_ram (
    .clk     (clk),
    .we      (e_we),
    .waddr   (e_waddr),
    .wdata   (e_wdata),
    .re_a    (e_re_a),
    .raddr_a (e_raddr_a),
    .rdata_a (e_rdata_a),
    .re_b    (e_re_b),
    .raddr_b (e_raddr_b),
    .rdata_b (e_rdata_b)
  );

  twqs_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_stack_ram (
    .clk     (clk),
    .we      (s_we),
    .waddr   (s_waddr),
    .wdata   (s_wdata),
    .re_a    (s_re),
    .raddr_a (s_raddr),
    .rdata_a (s_rdata),
    .re_b    (1'b0),
    .raddr_b ('0),
    .rdata_b ()
  );

  assign out_valid             = emit_pend_r;
  assign out_data.sorted_value = $signed(e_rdata_a);
  assign out_data.end_of_set   = last_r;
  assign out_data.overflow     = ovf_r;

endmodule

### rtl/twqs_checker.sv
// ----------------------------------------------------------------------------
// twqs_checker
// port level checks of load, sort and emission sequencing
// ----------------------------------------------------------------------------
`include "three_way_quicksort_assert.svh"

module twqs_checker
  import twqs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // results only come out during a sort cycle
  `TWQS_ASSERT_SAME(a_strobe_busy, out_valid, busy, "result strobe while not busy")

  // the final element always starts a sort
  `TWQS_ASSERT_NEXT(a_final_starts, start && !busy && in_data.final_element, busy, "final transfer did not start sort")

  // an ordinary load leaves the block ready and silent
  `TWQS_ASSERT_NEXT(a_load_quiet, start && !busy && !in_data.final_element, !busy && !out_valid, "load transfer caused busy or result")

  // results stream without gaps up to the end of the set, then the block frees up
  `TWQS_ASSERT_NEXT(a_stream_gapless, out_valid && !out_data.end_of_set, out_valid, "gap in result stream")
  `TWQS_ASSERT_NEXT(a_end_frees, out_valid && out_data.end_of_set, !busy && !out_valid, "block still busy after end of set")

endmodule

bind three_way_quicksort twqs_checker u_twqs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: three_way_quicksort testbench
// loads sets of signed elements through the start/busy port and checks every
// emitted result against a software sort of the loaded set, including the
// last-element flag and the overflow flag for sets larger than the store
// ----------------------------------------------------------------------------
module tb
  import twqs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH    = MAX_ELEMENTS_DEF;
  localparam int PHASE_ITEMS    = 115;    // random items per idling phase
  localparam int WATCHDOG_LIMIT = 60000;  // idle limit before the watchdog stops the test
  localparam int SETTLE_CYCLES  = 16;     // wait after draining before the final check
  localparam int DIRECTED_ITEMS = 22;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

  // value styles used for random sets
  typedef enum int {VALS_FULL, VALS_NARROW, VALS_EXTREME, VALS_MIXED} value_style_t;

  // --------------------------------------------------------------------------
  // expected-result store: collects the set being loaded, and on the final
  // element turns it into the ascending sequence of results the block owes
  // --------------------------------------------------------------------------
  class set_sorter;
    logic signed [ELEM_W-1:0] loading_set[$];
    bit                       store_overflowed;
    out_item_t                sorted_pending[$];
    int unsigned              mismatch_count;

    function void note_load(in_item_t it);
      logic signed [ELEM_W-1:0] ordered[$];
      logic signed [ELEM_W-1:0] key;
      out_item_t                r;
      int                       i;
      int                       j;
      // the store holds STORE_DEPTH entries; anything past that is dropped,
      // the final element included, but still flags the whole set
      if (loading_set.size() < STORE_DEPTH) loading_set.push_back(it.element);
      else store_overflowed = 1'b1;
      if (!it.final_element) return;
      // plain insertion sort; pivot choice in the block cannot change order
      ordered = loading_set;
      for (i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j+1] = ordered[j];
          j--;
        end
        ordered[j+1] = key;
      end
      for (i = 0; i < ordered.size(); i++) begin
        r.sorted_value = ordered[i];
        r.end_of_set   = (i == ordered.size() - 1);
        r.overflow     = store_overflowed;
        sorted_pending.push_back(r);
      end
      loading_set.delete();
      store_overflowed = 1'b0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (sorted_pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d end %0b ovf %0b",
                 $time, got.sorted_value, got.end_of_set, got.overflow);
        mismatch_count++;
        return;
      end
      exp = sorted_pending.pop_front();
      if (got.sorted_value !== exp.sorted_value) begin
        $display("%0t: sorted_value expected %0d got %0d",
                 $time, exp.sorted_value, got.sorted_value);
        mismatch_count++;
      end
      if (got.end_of_set !== exp.end_of_set) begin
        $display("%0t: end_of_set expected %0b got %0b", $time, exp.end_of_set, got.end_of_set);
        mismatch_count++;
      end
      if (got.overflow !== exp.overflow) begin
        $display("%0t: overflow expected %0b got %0b", $time, exp.overflow, got.overflow);
        mismatch_count++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  set_sorter sorter = new();
  int        idle_cycles;

  // directed sets: single extreme, reversed extremes, mixed signs,
  // all equal, duplicates around zero, already ascending, equal maxima
  logic signed [ELEM_W-1:0] directed_values [DIRECTED_ITEMS] = '{
    ELEM_MIN,
    ELEM_MAX, ELEM_MIN,
    0, -1, 1, ELEM_MAX, ELEM_MIN,
    5, 5, 5, 5,
    7, -7, 7, 0, -7,
    -2, -1, 0,
    ELEM_MAX, ELEM_MAX
  };
  bit directed_last [DIRECTED_ITEMS] = '{
    1,
    0, 1,
    0, 0, 0, 0, 1,
    0, 0, 0, 1,
    0, 0, 0, 0, 1,
    0, 0, 1,
    0, 1
  };

  three_way_quicksort #(
    .MAX_ELEMENTS(STORE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // results cannot be held off, so every strobe is one transfer to check
  always @(posedge clk) begin
    if (rst_n && out_valid) sorter.check_result(out_data);
  end

  // cycles without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // hold start high until the block takes the item; start is lowered only by
  // hold_off and drain_results, both of which wait at least one edge after it
  task automatic send_element(input in_item_t it);
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sorter.note_load(it);
  endtask

  // sender gap with junk on the data bus
  task automatic hold_off(input int cycles);
    start   <= 1'b0;
    in_data <= {ELEM_W'($urandom), 1'($urandom)};
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every owed result has come back
  task automatic drain_results();
    if (sorter.sorted_pending.size() == 0) return;
    start <= 1'b0;
    while (sorter.sorted_pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_value(input value_style_t style);
    value_style_t s;
    s = style;
    if (s == VALS_MIXED) s = value_style_t'($urandom_range(2));
    case (s)
      VALS_NARROW: return ELEM_W'($signed($urandom_range(6)) - 3);
      VALS_EXTREME: begin
        case ($urandom_range(4))
          0: return ELEM_MIN;
          1: return ELEM_MAX;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // mostly small sets, some medium, a few exactly full or overflowing
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 78) return $urandom_range(1, 12);
    if (r < 88) return $urandom_range(13, STORE_DEPTH - 1);
    if (r < 94) return STORE_DEPTH;
    return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
  endfunction

  task automatic send_set(input int count, input value_style_t style, input int gap_pct);
    in_item_t it;
    for (int k = 0; k < count; k++) begin
      it.element       = pick_value(style);
      it.final_element = (k == count - 1);
      if ($urandom_range(99) < gap_pct) hold_off($urandom_range(1, 4));
      send_element(it);
    end
  endtask

  initial begin
    in_item_t it;
    int       gap_pct;
    int       phase_count;
    int       set_size;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed sets, light sender gaps
    for (int d = 0; d < DIRECTED_ITEMS; d++) begin
      it.element       = directed_values[d];
      it.final_element = directed_last[d];
      if ($urandom_range(99) < 10) hold_off($urandom_range(1, 3));
      send_element(it);
    end
    drain_results();

    // three idling phases: sender gaps at 10%, then 48%, then none;
    // each phase opens with a set at or past the store size
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 10 : (phase == 1) ? 48 : 0;
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        if (phase_count == 0) begin
          set_size = (phase == 0) ? STORE_DEPTH + 2 :
                     (phase == 1) ? STORE_DEPTH : STORE_DEPTH + 1;
        end else begin
          set_size = pick_set_size();
        end
        send_set(set_size, value_style_t'($urandom_range(3)), gap_pct);
        phase_count += set_size;
        // now and then let the whole set stream out before the next one
        if ($urandom_range(5) == 0) drain_results();
      end
      drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sorter.mismatch_count == 0 && sorter.sorted_pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
